@@ rtl/core/vcct_pkg.sv @@
`default_nettype none

package vcct_pkg;

   localparam int NUM_VCS   = 8;
   localparam int VC_W      = 3;
   localparam int ACT_W     = $clog2(NUM_VCS + 1);
   localparam int OCC_W     = 9;
   localparam int SLOT_W    = 8;
   localparam int EXC_W     = OCC_W + 1;
   localparam int PROD_W    = EXC_W + ACT_W;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = SLOT_W;
   localparam int MODE_W    = 2;
   localparam int ERR_W     = 3;

   localparam logic [OCC_W-1:0]  OCC_MAX             = '1;
   localparam logic [SLOT_W-1:0] PRIVATE_SLOTS_RESET = SLOT_W'(8);

   typedef enum logic [MODE_W-1:0] {
      MODE_CREDIT = 2'd0,
      MODE_SEND   = 2'd1,
      MODE_TAKE   = 2'd2,
      MODE_QUERY  = 2'd3
   } mode_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE        = 3'd0,
      ERR_CREDIT_IDLE = 3'd1,
      ERR_UNDERFLOW   = 3'd2,
      ERR_SEND_FULL   = 3'd3,
      ERR_TAKE_IN_USE = 3'd4
   } error_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PRIVATE_SLOTS = 3'd0,
      CSR_SHARED_SLOTS  = 3'd1,
      CSR_DYN_SHARE     = 3'd2,
      CSR_RELEASE_TAIL  = 3'd3,
      CSR_BUSY_FULL     = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [SLOT_W-1:0] private_slots;
      logic [SLOT_W-1:0] shared_slots;
      logic              dynamic_share_en;
      logic              release_on_tail_credit;
      logic              busy_when_full;
   } csr_type;

endpackage

`default_nettype wire

@@ rtl/core/vcct_if.sv @@
`default_nettype none

interface vcct_req_if;
   import vcct_pkg::*;

   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [VC_W-1:0]   vc;
   logic              is_tail;

   modport source (output valid, output mode, output vc, output is_tail, input ready);
   modport sink   (input valid, input mode, input vc, input is_tail, output ready);
endinterface

interface vcct_rsp_if;
   import vcct_pkg::*;

   logic             valid;
   logic             ready;
   logic [ERR_W-1:0] error_code;
   logic             is_full;
   logic             is_empty;
   logic             is_available;
   logic             has_credit;
   logic [OCC_W-1:0] occupancy;

   modport source (output valid, output error_code, output is_full, output is_empty,
                   output is_available, output has_credit, output occupancy, input ready);
   modport sink   (input valid, input error_code, input is_full, input is_empty,
                   input is_available, input has_credit, input occupancy, output ready);
endinterface

`default_nettype wire

@@ rtl/core/vc_credit_tracker_shared_buffer.sv @@
// A request transfer is registered in the input stage and processed once the response
// register is free; its response is then registered and offered on the rsp channel.
// Throughput: one request per cycle, set by the read-modify-write of the per-VC
// state and pool counters; a stalled rsp channel holds the pipeline.
// Reset: synchronous, active high; clears VC state, counters and valids, and
// returns the CSRs to their defaults (private 8, all others 0).
`default_nettype none

module vc_credit_tracker_shared_buffer (
   input  wire                            clock,
   input  wire                            reset,
   vcct_req_if.sink                       req_chan,
   vcct_rsp_if.source                     rsp_chan,
   input  wire                            csr_write_en,
   input  wire [vcct_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire [vcct_pkg::CSR_DAT_W-1:0]  csr_wdata
);
   import vcct_pkg::*;

   localparam logic [VC_W:0] NumVcsW = (VC_W + 1)'(NUM_VCS);

   csr_type csr_ff, csr_in;

   logic              in_valid_ff, in_valid_in;
   mode_type          in_mode_ff;
   logic [VC_W-1:0]   in_vc_ff;
   logic              in_tail_ff;

   logic [OCC_W-1:0]   occ_ff [NUM_VCS];
   logic [NUM_VCS-1:0] in_use_ff;
   logic [NUM_VCS-1:0] tail_sent_ff;
   logic [OCC_W-1:0]   pool_ff, pool_in;
   logic [ACT_W-1:0]   active_ff, active_in;

   logic              out_valid_ff, out_valid_in;
   logic [ERR_W-1:0]  out_err_ff, out_err_in;
   logic              out_full_ff, out_full_in;
   logic              out_empty_ff, out_empty_in;
   logic              out_avail_ff, out_avail_in;
   logic              out_credit_ff, out_credit_in;
   logic [OCC_W-1:0]  out_occ_ff, out_occ_in;

   logic              req_xfer;
   logic              fire;
   logic              vc_ok;
   logic              upd_en;

   logic [OCC_W-1:0]  occ_cur, occ_in;
   logic              in_use_cur, in_use_in;
   logic              tail_cur, tail_in;
   error_type         err;
   logic [OCC_W-1:0]  priv_ext;
   logic [OCC_W-1:0]  shared_ext;
   logic              full_cur;
   logic              full_new;
   logic [EXC_W-1:0]  excess;
   logic [PROD_W-1:0] share_prod;

   // handshake
   assign fire          = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || fire;
   assign req_xfer      = req_chan.valid && req_chan.ready;
   assign in_valid_in   = req_xfer ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign out_valid_in  = fire ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.error_code   = out_err_ff;
   assign rsp_chan.is_full      = out_full_ff;
   assign rsp_chan.is_empty     = out_empty_ff;
   assign rsp_chan.is_available = out_avail_ff;
   assign rsp_chan.has_credit   = out_credit_ff;
   assign rsp_chan.occupancy    = out_occ_ff;

   // CSR writes
   always_comb begin
      csr_in = csr_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_PRIVATE_SLOTS: csr_in.private_slots          = csr_wdata;
            CSR_SHARED_SLOTS:  csr_in.shared_slots           = csr_wdata;
            CSR_DYN_SHARE:     csr_in.dynamic_share_en       = csr_wdata[0];
            CSR_RELEASE_TAIL:  csr_in.release_on_tail_credit = csr_wdata[0];
            CSR_BUSY_FULL:     csr_in.busy_when_full         = csr_wdata[0];
            default:           csr_in = csr_ff;
         endcase
      end
   end

   // event processing
   assign vc_ok      = ({1'b0, in_vc_ff} < NumVcsW);
   assign upd_en     = fire && vc_ok;
   assign priv_ext   = {1'b0, csr_ff.private_slots};
   assign shared_ext = {1'b0, csr_ff.shared_slots};

   always_comb begin
      occ_cur    = occ_ff[in_vc_ff];
      in_use_cur = in_use_ff[in_vc_ff];
      tail_cur   = tail_sent_ff[in_vc_ff];
      full_cur   = (occ_cur >= priv_ext) && (pool_ff >= shared_ext);

      occ_in    = occ_cur;
      in_use_in = in_use_cur;
      tail_in   = tail_cur;
      pool_in   = pool_ff;
      active_in = active_ff;
      err       = ERR_NONE;

      case (in_mode_ff)
         MODE_CREDIT: begin
            if (csr_ff.release_on_tail_credit && !in_use_cur) begin
               err = ERR_CREDIT_IDLE;
            end else if (occ_cur == '0) begin
               err = ERR_UNDERFLOW;
            end else begin
               if (occ_cur > priv_ext && pool_ff != '0) begin
                  pool_in = pool_ff - OCC_W'(1);
               end
               occ_in = occ_cur - OCC_W'(1);
               if (csr_ff.release_on_tail_credit && occ_in == '0 && tail_cur && in_use_cur) begin
                  in_use_in = 1'b0;
                  if (active_ff != '0) begin
                     active_in = active_ff - ACT_W'(1);
                  end
               end
            end
         end
         MODE_SEND: begin
            if (full_cur || occ_cur >= OCC_MAX) begin
               err = ERR_SEND_FULL;
            end else begin
               if (occ_cur >= priv_ext) begin
                  pool_in = pool_ff + OCC_W'(1);
               end
               occ_in = occ_cur + OCC_W'(1);
               if (in_tail_ff) begin
                  tail_in = 1'b1;
                  if (!csr_ff.release_on_tail_credit && in_use_cur) begin
                     in_use_in = 1'b0;
                     if (active_ff != '0) begin
                        active_in = active_ff - ACT_W'(1);
                     end
                  end
               end
            end
         end
         MODE_TAKE: begin
            if (in_use_cur) begin
               err = ERR_TAKE_IN_USE;
            end else begin
               in_use_in = 1'b1;
               tail_in   = 1'b0;
               active_in = active_ff + ACT_W'(1);
            end
         end
         default: begin
         end
      endcase

      full_new   = (occ_in >= priv_ext) && (pool_in >= shared_ext);
      excess     = {1'b0, occ_in} - {2'b00, csr_ff.private_slots} + EXC_W'(1);
      share_prod = PROD_W'(excess) * PROD_W'(active_in);

      out_err_in    = err;
      out_full_in   = full_new;
      out_empty_in  = (occ_in == '0);
      out_avail_in  = !in_use_in && (!csr_ff.busy_when_full || !full_new);
      out_credit_in = (occ_in < priv_ext) ||
                      ((pool_in < shared_ext) &&
                       (!csr_ff.dynamic_share_en || active_in == '0 ||
                        share_prod <= PROD_W'(csr_ff.shared_slots)));
      out_occ_in    = occ_in;

      if (!vc_ok) begin
         out_err_in    = ERR_NONE;
         out_full_in   = 1'b0;
         out_empty_in  = 1'b0;
         out_avail_in  = 1'b0;
         out_credit_in = 1'b0;
         out_occ_in    = '0;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.private_slots          <= PRIVATE_SLOTS_RESET;
         csr_ff.shared_slots           <= '0;
         csr_ff.dynamic_share_en       <= 1'b0;
         csr_ff.release_on_tail_credit <= 1'b0;
         csr_ff.busy_when_full         <= 1'b0;
         in_valid_ff                   <= 1'b0;
         out_valid_ff                  <= 1'b0;
         in_use_ff                     <= '0;
         tail_sent_ff                  <= '0;
         pool_ff                       <= '0;
         active_ff                     <= '0;
         for (int i = 0; i < NUM_VCS; i++) begin
            occ_ff[i] <= '0;
         end
      end else begin
         csr_ff       <= csr_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (upd_en) begin
            occ_ff[in_vc_ff]       <= occ_in;
            in_use_ff[in_vc_ff]    <= in_use_in;
            tail_sent_ff[in_vc_ff] <= tail_in;
            pool_ff                <= pool_in;
            active_ff              <= active_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_mode_ff <= mode_type'(req_chan.mode);
         in_vc_ff   <= req_chan.vc;
         in_tail_ff <= req_chan.is_tail;
      end
      if (fire) begin
         out_err_ff    <= out_err_in;
         out_full_ff   <= out_full_in;
         out_empty_ff  <= out_empty_in;
         out_avail_ff  <= out_avail_in;
         out_credit_ff <= out_credit_in;
         out_occ_ff    <= out_occ_in;
      end
   end

endmodule

`default_nettype wire
